/* hdl/gstk_pkg.sv */
package gstk_pkg;

    localparam int TOP_COUNT_DEF = 3;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 16;
    localparam int RANK_W  = 5;
    localparam int TOTAL_W = 32;
    localparam int GROUP_W = 16;
    localparam int SUM_W   = 36;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_CLOSE  = 2'd1,
        CMD_REPORT = 2'd2
    } cmd_t;

    typedef enum logic {
        KIND_CLOSE = 1'b0,
        KIND_ENTRY = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_TRIM,
        ST_EMIT,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
    } sample_t;

    typedef struct packed {
        logic               kind;
        logic [RANK_W-1:0]  rank;
        logic [TOTAL_W-1:0] total;
        logic [GROUP_W-1:0] group_number;
        logic [SUM_W-1:0]   top_sum;
        logic               last;
    } result_t;

endpackage

/* hdl/gstk_stream_if.sv */
interface gstk_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hdl/grouped_sum_top_k_tracker.sv */
// Grouped-sum top-K tracker. Each request on the sample channel carries a
// command and a 16-bit value: add folds the value into the saturating group
// total; close offers the group total to a list of the TOP_COUNT largest
// totals (ties keep the older entry) and returns one result with its rank
// (TOP_COUNT if it did not enter), its group number and the sum of the listed
// totals; report returns the TOP_COUNT entries largest first, last set on the
// final one. A single 32-bit comparator walks the list one entry per cycle and
// a single 36-bit adder updates the list sum with an add then a subtract. A
// close scans, then on a hit inserts and trims before it emits its result; a
// report emits one entry at a time; both wait while the result channel stalls.
// The sample channel is ready only while the sequencer is idle; one finished
// result may wait in the output register while the next request is taken.
module grouped_sum_top_k_tracker
    import gstk_pkg::*;
#(
    parameter int TOP_COUNT = TOP_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    gstk_stream_if.sink          sample,
    gstk_stream_if.source        result
);

    localparam int IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TOP_COUNT - 1);
    localparam logic [RANK_W-1:0] RANK_NONE = RANK_W'(TOP_COUNT);

    state_t               state_reg, state_next;
    logic [TOTAL_W-1:0]   running_total_reg, running_total_next;
    logic [GROUP_W-1:0]   group_counter_reg, group_counter_next;
    logic [TOTAL_W-1:0]   best_totals_reg [TOP_COUNT];
    logic [TOTAL_W-1:0]   best_totals_next [TOP_COUNT];
    logic [GROUP_W-1:0]   best_groups_reg [TOP_COUNT];
    logic [GROUP_W-1:0]   best_groups_next [TOP_COUNT];
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [TOTAL_W-1:0]   cur_total_reg, cur_total_next;
    logic [GROUP_W-1:0]   cur_group_reg, cur_group_next;
    logic [TOTAL_W-1:0]   dropped_reg, dropped_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [RANK_W-1:0]    rank_reg, rank_next;
    result_t              result_reg, result_next;
    logic                 result_valid_reg, result_valid_next;

    logic                 accept;
    logic                 slot_free;
    logic                 hit;
    logic [TOTAL_W:0]     add_wide;
    logic [SUM_W-1:0]     sum_operand;
    logic                 sum_carry_in;

    assign sample.ready   = (state_reg == ST_IDLE);
    assign accept         = sample.valid && sample.ready;
    assign slot_free      = !result_valid_reg || result.ready;
    assign result.valid   = result_valid_reg;
    assign result.payload = result_reg;

    // The shared compare: current total against the entry under the scan index.
    assign hit = cur_total_reg > best_totals_reg[idx_reg];

    assign add_wide = {1'b0, running_total_reg} + {{(TOTAL_W-VALUE_W+1){1'b0}},
                                                   sample.payload.value};

    // Shared list-sum adder: add the new total, then subtract the dropped one.
    always_comb
    begin
        if (state_reg == ST_TRIM)
        begin
            sum_operand  = ~{{(SUM_W-TOTAL_W){1'b0}}, dropped_reg};
            sum_carry_in = 1'b1;
        end
        else
        begin
            sum_operand  = {{(SUM_W-TOTAL_W){1'b0}}, cur_total_reg};
            sum_carry_in = 1'b0;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (sample.payload.cmd)
                        CMD_CLOSE:  state_next = ST_SCAN;
                        CMD_REPORT: state_next = ST_REPORT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit)
                    state_next = ST_INSERT;
                else if (idx_reg == IDX_LAST)
                    state_next = ST_EMIT;
            end
            ST_INSERT: state_next = ST_TRIM;
            ST_TRIM:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            ST_REPORT:
            begin
                if (slot_free && idx_reg == IDX_LAST)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath
    always_comb
    begin
        running_total_next = running_total_reg;
        group_counter_next = group_counter_reg;
        best_totals_next   = best_totals_reg;
        best_groups_next   = best_groups_reg;
        sum_next           = sum_reg;
        cur_total_next     = cur_total_reg;
        cur_group_next     = cur_group_reg;
        dropped_next       = dropped_reg;
        idx_next           = idx_reg;
        rank_next          = rank_reg;
        result_next        = result_reg;
        result_valid_next  = result_valid_reg && !result.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    case (sample.payload.cmd)
                        CMD_ADD:
                        begin
                            running_total_next = add_wide[TOTAL_W] ? '1
                                                 : add_wide[TOTAL_W-1:0];
                        end
                        CMD_CLOSE:
                        begin
                            cur_total_next     = running_total_reg;
                            cur_group_next     = group_counter_reg;
                            rank_next          = RANK_NONE;
                            running_total_next = '0;
                            if (group_counter_reg != '1)
                                group_counter_next = group_counter_reg + GROUP_W'(1);
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit)
                    rank_next = RANK_W'(idx_reg);
                else if (idx_reg != IDX_LAST)
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_INSERT:
            begin
                dropped_next = best_totals_reg[TOP_COUNT-1];
                for (int i = 0; i < TOP_COUNT; i++)
                begin
                    if (RANK_W'(i) == rank_reg)
                    begin
                        best_totals_next[i] = cur_total_reg;
                        best_groups_next[i] = cur_group_reg;
                    end
                    else if (i > 0 && RANK_W'(i) > rank_reg)
                    begin
                        best_totals_next[i] = best_totals_reg[(i > 0) ? i-1 : 0];
                        best_groups_next[i] = best_groups_reg[(i > 0) ? i-1 : 0];
                    end
                end
                sum_next = sum_reg + sum_operand + SUM_W'(sum_carry_in);
            end
            ST_TRIM:
            begin
                sum_next = sum_reg + sum_operand + SUM_W'(sum_carry_in);
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    result_valid_next        = 1'b1;
                    result_next.kind         = KIND_CLOSE;
                    result_next.rank         = rank_reg;
                    result_next.total        = cur_total_reg;
                    result_next.group_number = cur_group_reg;
                    result_next.top_sum      = sum_reg;
                    result_next.last         = 1'b1;
                end
            end
            ST_REPORT:
            begin
                if (slot_free)
                begin
                    result_valid_next        = 1'b1;
                    result_next.kind         = KIND_ENTRY;
                    result_next.rank         = RANK_W'(idx_reg);
                    result_next.total        = best_totals_reg[idx_reg];
                    result_next.group_number = best_groups_reg[idx_reg];
                    result_next.top_sum      = sum_reg;
                    result_next.last         = (idx_reg == IDX_LAST);
                    if (idx_reg != IDX_LAST)
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            running_total_reg <= '0;
            group_counter_reg <= '0;
            sum_reg           <= '0;
            idx_reg           <= '0;
            rank_reg          <= '0;
            result_valid_reg  <= 1'b0;
            for (int i = 0; i < TOP_COUNT; i++)
            begin
                best_totals_reg[i] <= '0;
                best_groups_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg         <= state_next;
            running_total_reg <= running_total_next;
            group_counter_reg <= group_counter_next;
            sum_reg           <= sum_next;
            idx_reg           <= idx_next;
            rank_reg          <= rank_next;
            result_valid_reg  <= result_valid_next;
            best_totals_reg   <= best_totals_next;
            best_groups_reg   <= best_groups_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_total_reg <= cur_total_next;
        cur_group_reg <= cur_group_next;
        dropped_reg   <= dropped_next;
        result_reg    <= result_next;
    end

    // The list stays sorted, largest first.
    a_list_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> best_totals_reg[0] >= best_totals_reg[TOP_COUNT-1])
        else $error("top list out of order");

    // The list sum covers at least the largest entry once the trim is done.
    a_sum_covers_head: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> sum_reg >= {{(SUM_W-TOTAL_W){1'b0}}, best_totals_reg[0]})
        else $error("list sum below largest entry");

    // Insertion only follows a hit, so the rank names a real slot.
    a_insert_rank: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INSERT |-> rank_reg < RANK_NONE && $past(state_reg) == ST_SCAN)
        else $error("insert without valid rank");

    // A close result reports a rank that matches its entry in the list.
    a_close_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && slot_free && rank_reg < RANK_NONE
        |-> best_totals_reg[rank_reg[IDX_W-1:0]] == cur_total_reg)
        else $error("closed total missing from its slot");

endmodule

/* dv/tb_grouped_sum_top_k_tracker.sv */
`timescale 1ns / 1ps

module tb_grouped_sum_top_k_tracker;
    import gstk_pkg::*;

    localparam int TOPK = TOP_COUNT_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int ITEM_TARGET   = 360;
    localparam int HOLD_AT       = 25;
    localparam int HOLD_CYCLES   = 120;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef struct {
        sample_t req;
        int      gap;
    } queued_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gstk_stream_if #(.payload_t(sample_t)) sample_ch ();
    gstk_stream_if #(.payload_t(result_t)) result_ch ();

    grouped_sum_top_k_tracker #(
        .TOP_COUNT(TOPK)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predicted tracker state.
    logic [TOTAL_W-1:0] acc_total = '0;
    logic [GROUP_W-1:0] next_group = '0;
    logic [TOTAL_W-1:0] top_totals [TOPK] = '{default: '0};
    logic [GROUP_W-1:0] top_groups [TOPK] = '{default: '0};

    result_t     due_results [$];
    queued_req_t pending_reqs [$];
    queued_req_t next_req;

    int  error_count = 0;
    int  results_seen = 0;
    int  real_reqs = 0;
    int  send_wait = 0;
    int  recv_wait = 0;
    int  cycle_count = 0;
    bit  sender_calm = 1'b0;

    function automatic logic [SUM_W-1:0] list_total();
        logic [SUM_W-1:0] acc;
        acc = '0;
        foreach (top_totals[i])
            acc += SUM_W'(top_totals[i]);
        return acc;
    endfunction

    task automatic update_top_list(input sample_t req);
        result_t     r;
        logic [32:0] wide;
        int          place;
        r = '0;
        case (req.cmd)
            CMD_ADD:
            begin
                wide = {1'b0, acc_total} + {17'd0, req.value};
                acc_total = wide[32] ? '1 : wide[31:0];
            end
            CMD_CLOSE:
            begin
                // list is sorted largest first: take the first slot strictly below
                place = TOPK;
                for (int i = TOPK - 1; i >= 0; i--)
                begin
                    if (acc_total > top_totals[i])
                        place = i;
                end
                if (place < TOPK)
                begin
                    for (int i = TOPK - 1; i > place; i--)
                    begin
                        top_totals[i] = top_totals[i-1];
                        top_groups[i] = top_groups[i-1];
                    end
                    top_totals[place] = acc_total;
                    top_groups[place] = next_group;
                end
                r.kind         = KIND_CLOSE;
                r.rank         = RANK_W'(place);
                r.total        = acc_total;
                r.group_number = next_group;
                r.top_sum      = list_total();
                r.last         = 1'b1;
                due_results.push_back(r);
                acc_total = '0;
                if (next_group != {GROUP_W{1'b1}})
                    next_group++;
            end
            CMD_REPORT:
            begin
                for (int i = 0; i < TOPK; i++)
                begin
                    r.kind         = KIND_ENTRY;
                    r.rank         = RANK_W'(i);
                    r.total        = top_totals[i];
                    r.group_number = top_groups[i];
                    r.top_sum      = list_total();
                    r.last         = (i == TOPK - 1);
                    due_results.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
        queued_req_t q;
        q.req.cmd   = cmd;
        q.req.value = value;
        q.gap       = sender_calm ? 0 : $urandom_range(0, 4);
        if (cmd != CMD_UNUSED)
            real_reqs++;
        pending_reqs.push_back(q);
    endtask

    task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                               input logic [SUM_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (due_results.size() == 0)
        begin
            error_count++;
            $display("%0t: result with nothing due, expected none actual %0h", $time, got);
            return;
        end
        want = due_results.pop_front();
        check_field("kind", SUM_W'(want.kind), SUM_W'(got.kind));
        check_field("rank", SUM_W'(want.rank), SUM_W'(got.rank));
        check_field("total", SUM_W'(want.total), SUM_W'(got.total));
        check_field("group_number", SUM_W'(want.group_number), SUM_W'(got.group_number));
        check_field("top_sum", want.top_sum, got.top_sum);
        check_field("last", SUM_W'(want.last), SUM_W'(got.last));
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || sample_ch.valid || due_results.size() != 0)
            @(negedge clk);
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid   <= 1'b0;
            sample_ch.payload <= '0;
            send_wait = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                update_top_list(sample_ch.payload);
            // hold the request until it is taken
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    sample_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    next_req = pending_reqs.pop_front();
                    sample_ch.valid   <= 1'b1;
                    sample_ch.payload <= next_req.req;
                    send_wait = next_req.gap;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor and sink stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                check_result(result_ch.payload);
                results_seen++;
                if (((results_seen / 40) % 3) == 2)
                    recv_wait = 0;
                else
                    recv_wait = $urandom_range(0, 4);
                // one long hold-off so the block backs up into the request side
                if (results_seen == HOLD_AT)
                    recv_wait = HOLD_CYCLES;
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int               pick;
        int               len;
        int               style;
        logic [VALUE_W-1:0] v;

        // empty list, empty group, then ties against equal totals
        queue_req(CMD_REPORT, 16'h0000);
        queue_req(CMD_CLOSE, 16'hFFFF);
        queue_req(CMD_ADD, 16'h0000);
        queue_req(CMD_ADD, 16'hFFFF);
        queue_req(CMD_CLOSE, 16'h0000);
        queue_req(CMD_ADD, 16'hFFFF);
        queue_req(CMD_CLOSE, 16'h0000);
        queue_req(CMD_ADD, 16'hFFFF);
        queue_req(CMD_CLOSE, 16'h0000);
        queue_req(CMD_ADD, 16'hFFFF);
        queue_req(CMD_CLOSE, 16'h0000);
        queue_req(CMD_UNUSED, 16'hFFFF);
        queue_req(CMD_ADD, 16'h0001);
        queue_req(CMD_CLOSE, 16'h0000);
        queue_req(CMD_ADD, 16'hFFFF);
        queue_req(CMD_ADD, 16'h0001);
        queue_req(CMD_CLOSE, 16'h0000);
        queue_req(CMD_REPORT, 16'hFFFF);
        queue_req(CMD_ADD, 16'h5555);
        queue_req(CMD_ADD, 16'hAAAA);
        queue_req(CMD_CLOSE, 16'h0000);
        queue_req(CMD_UNUSED, 16'h0000);
        queue_req(CMD_REPORT, 16'h0000);

        while (real_reqs < ITEM_TARGET)
        begin
            sender_calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                queue_req(CMD_UNUSED, VALUE_W'($urandom_range(0, 65535)));
            else if (pick <= 2)
                queue_req(CMD_REPORT, VALUE_W'($urandom_range(0, 65535)));
            else if (pick == 3)
                queue_req(CMD_CLOSE, VALUE_W'($urandom_range(0, 65535)));
            else
            begin
                len = $urandom_range(1, 8);
                style = $urandom_range(0, 3);
                for (int j = 0; j < len; j++)
                begin
                    case (style)
                        0: v = VALUE_W'($urandom_range(0, 65535));
                        1: v = VALUE_W'($urandom_range(0, 255));
                        2: v = '1;
                        default: v = 16'h1000;
                    endcase
                    queue_req(CMD_ADD, v);
                    if ($urandom_range(0, 15) == 0)
                        queue_req(CMD_REPORT, VALUE_W'($urandom_range(0, 65535)));
                end
                queue_req(CMD_CLOSE, VALUE_W'($urandom_range(0, 65535)));
            end
        end
        sender_calm = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();

        repeat (40) queue_req(CMD_ADD, 16'hFFFF);
        queue_req(CMD_CLOSE, 16'h0000);
        queue_req(CMD_REPORT, 16'h0000);
        repeat (3) queue_req(CMD_ADD, VALUE_W'($urandom_range(0, 65535)));
        queue_req(CMD_CLOSE, 16'h0000);
        queue_req(CMD_REPORT, 16'h0000);
        wait_drained();

        repeat (2 * TOPK + 8) @(posedge clk);
        if (error_count == 0 && due_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
